@@ sv/bfpa_pkg.sv @@
// package for the best-fit partition allocator
// word types, status codes and size constants; no dependencies
`default_nettype none
package bfpa_pkg;
    localparam int unsigned MAX_HOLES_DEF = 16;
    localparam int unsigned MAX_JOBS_DEF  = 16;
    localparam logic [15:0] RESET_TOTAL   = 16'd640;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FULL    = 3'd3,
        ST_DUP     = 3'd4
    } t_status;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  job_id;
        logic [15:0] req_size;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] region_start;
        logic [15:0] region_size;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [15:0] hs;
        logic [15:0] he;
    } t_hole;

    typedef struct packed {
        logic        valid;
        logic [7:0]  id;
        logic [15:0] js;
        logic [15:0] jsz;
    } t_job;

    // hole chain operation, applied by every cell in the same cycle
    typedef enum logic [3:0] {
        HOP_NONE  = 4'b0001,
        HOP_SHL   = 4'b0010,
        HOP_SHR   = 4'b0100,
        HOP_WRITE = 4'b1000
    } t_hop;

    typedef struct packed {
        logic        init;
        logic [15:0] total;
        t_hop        op;
        logic [7:0]  pos;
        t_hole       wr;
    } t_hole_ctl;
endpackage
`default_nettype wire

@@ sv/bfpa_hole_cell.sv @@
// one cell of the hole chain: holds one hole and shifts with its neighbours
// depends on bfpa_pkg
`default_nettype none
module bfpa_hole_cell
    import bfpa_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_hole_ctl  i_ctl,
    input  t_hole      i_left,
    input  t_hole      i_right,
    output t_hole      o_hole
);
    t_hole r_hole, n_hole;

    always_comb begin
        n_hole = r_hole;
        if (i_ctl.init) begin
            n_hole = '0;
            if (IDX == 0 && i_ctl.total != 16'd0) begin
                n_hole.valid = 1'b1;
                n_hole.hs    = 16'd1;
                n_hole.he    = i_ctl.total;
            end
        end else begin
            unique case (i_ctl.op)
                HOP_SHL: if (IDX >= i_ctl.pos) n_hole = i_right;
                HOP_SHR: begin
                    if (IDX > i_ctl.pos) n_hole = i_left;
                    else if (IDX == i_ctl.pos) n_hole = i_ctl.wr;
                end
                HOP_WRITE: if (IDX == i_ctl.pos) n_hole = i_ctl.wr;
                default: n_hole = r_hole;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hole <= (IDX == 0) ? t_hole'{valid: 1'b1, hs: 16'd1, he: RESET_TOTAL}
                                 : t_hole'('0);
        end else begin
            r_hole <= n_hole;
        end
    end

    assign o_hole = r_hole;
endmodule
`default_nettype wire

@@ sv/best_fit_partition_allocator.sv @@
// best-fit partition allocator top level: sequencer, job table, hole chain
// depends on bfpa_pkg and bfpa_hole_cell
//
// usage: one input word (mode, job id, size) is taken on i_in_valid with
// o_in_stall low; one output word (status, start, size) follows on o_out_valid.
// i_cfg_we writes total_size and rebuilds the hole list to one hole (none when the size is 0).
// each request walks the hole chain one entry a cycle through a single
// compare unit; the job table is searched combinationally, and a new
// request is taken only after the last one is through.
// after reset total_size is 640, one hole 1..640, no jobs.
// the output register holds the word while i_out_stall is high; the next
// request is taken and scanned meanwhile, then waits at the end of its scan
// until the register is free, with o_in_stall high.
`default_nettype none
module best_fit_partition_allocator
    import bfpa_pkg::*;
#(
    parameter int unsigned MAX_HOLES = MAX_HOLES_DEF,
    parameter int unsigned MAX_JOBS  = MAX_JOBS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_word   o_out_data
);
    localparam int HW = $clog2(MAX_HOLES + 1);
    localparam int HI = $clog2(MAX_HOLES);
    localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    t_in_word     r_req;
    logic [HW-1:0] r_idx, r_cnt, r_best, r_pos;
    logic         r_found, r_posf;
    logic [15:0]  r_bsz;
    t_out_word    r_out;
    logic         r_out_v;
    t_job         r_job [MAX_JOBS];
    t_hole        w_hole [MAX_HOLES];
    t_hole_ctl    w_ctl;

    // job table lookups
    logic          w_hit, w_free_av;
    logic [JW-1:0] w_hit_i, w_free_i;
    always_comb begin
        w_hit = 1'b0; w_hit_i = '0; w_free_av = 1'b0; w_free_i = '0;
        for (int j = MAX_JOBS - 1; j >= 0; j--) begin
            if (r_job[j].valid && r_job[j].id == r_req.job_id) begin
                w_hit = 1'b1; w_hit_i = JW'(j);
            end
            if (!r_job[j].valid) begin
                w_free_av = 1'b1; w_free_i = JW'(j);
            end
        end
    end

    // scan element
    t_hole        w_cur;
    logic [15:0]  w_csz;
    assign w_cur = (r_idx < HW'(MAX_HOLES)) ? w_hole[r_idx[HI-1:0]] : '0;
    assign w_csz = w_cur.he - w_cur.hs + 16'd1;

    t_hole w_best;
    assign w_best = w_hole[r_best[HI-1:0]];

    // free region
    logic [15:0] w_fs, w_fe;
    assign w_fs = r_job[w_hit_i].js;
    assign w_fe = w_fs + r_job[w_hit_i].jsz - 16'd1;

    logic [HW-1:0] w_pos_m1;
    assign w_pos_m1 = r_pos - HW'(1);

    t_hole w_lh, w_rh;
    assign w_lh = (r_pos != '0) ? w_hole[w_pos_m1[HI-1:0]] : '0;
    assign w_rh = (r_pos < r_cnt) ? w_hole[r_pos[HI-1:0]] : '0;

    logic w_left, w_right;
    assign w_left  = (r_pos != '0) && (w_lh.he + 16'd1 == w_fs);
    assign w_right = (r_pos < r_cnt) && (w_fe + 16'd1 == w_rh.hs);

    logic    w_done_scan;
    assign w_done_scan = (r_idx >= HW'(MAX_HOLES)) || !w_cur.valid;

    // result word of the current request
    t_out_word w_res;
    logic      w_alloc_ok, w_free_ok;
    always_comb begin
        w_res = '0;
        w_alloc_ok = 1'b0;
        w_free_ok = 1'b0;
        if (r_req.mode == MODE_ALLOC) begin
            if (w_hit) w_res.status = ST_DUP;
            else if (!w_free_av) w_res.status = ST_FULL;
            else if (r_req.req_size == 16'd0 || !r_found) w_res.status = ST_NOFIT;
            else begin
                w_alloc_ok = 1'b1;
                w_res.status = ST_OK;
                w_res.region_start = w_best.hs;
                w_res.region_size = r_req.req_size;
            end
        end else if (!w_hit) begin
            w_res.status = ST_UNKNOWN;
        end else if (!w_left && !w_right && r_cnt >= HW'(MAX_HOLES)) begin
            w_res.status = ST_FULL;
        end else begin
            w_free_ok = 1'b1;
            w_res.status = ST_OK;
            w_res.region_start = w_fs;
            w_res.region_size = r_job[w_hit_i].jsz;
        end
    end

    always_comb begin
        n_state = r_state;
        w_ctl = '0;
        w_ctl.op = HOP_NONE;
        w_ctl.init = i_cfg_we;
        w_ctl.total = i_cfg_data;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_SCAN;
            S_SCAN:  if (w_done_scan && (!r_out_v || !i_out_stall)) n_state = S_APPLY;
            S_APPLY: begin
                n_state = S_RESP;
                if (r_req.mode == MODE_ALLOC) begin
                    if (w_alloc_ok) begin
                        w_ctl.pos = 8'(r_best);
                        if (r_bsz == r_req.req_size) begin
                            w_ctl.op = HOP_SHL;
                        end else begin
                            w_ctl.op = HOP_WRITE;
                            w_ctl.wr = w_best;
                            w_ctl.wr.hs = w_ctl.wr.hs + r_req.req_size;
                        end
                    end
                end else if (w_hit) begin
                    if (w_left && w_right) begin
                        w_ctl.op = HOP_SHL;
                        w_ctl.pos = 8'(r_pos);
                    end else if (w_left) begin
                        w_ctl.op = HOP_WRITE;
                        w_ctl.pos = 8'(w_pos_m1);
                        w_ctl.wr = w_lh; w_ctl.wr.he = w_fe;
                    end else if (w_right) begin
                        w_ctl.op = HOP_WRITE;
                        w_ctl.pos = 8'(r_pos);
                        w_ctl.wr = w_rh; w_ctl.wr.hs = w_fs;
                    end else if (r_cnt < HW'(MAX_HOLES)) begin
                        w_ctl.op = HOP_SHR;
                        w_ctl.pos = 8'(r_pos);
                        w_ctl.wr = '{valid: 1'b1, hs: w_fs, he: w_fe};
                    end
                end
            end
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // merged left-and-right: drop right hole, then extend left one
    logic r_merge_fix;
    logic [15:0] r_merge_end;
    logic [HW-1:0] r_merge_pos;

    genvar g;
    generate
        for (g = 0; g < MAX_HOLES; g++) begin : g_cell
            t_hole w_l, w_r;
            t_hole_ctl w_c;
            assign w_l = (g == 0) ? t_hole'('0) : w_hole[(g + MAX_HOLES - 1) % MAX_HOLES];
            assign w_r = (g == MAX_HOLES - 1) ? t_hole'('0) : w_hole[(g + 1) % MAX_HOLES];
            always_comb begin
                w_c = w_ctl;
                if (r_merge_fix && !w_ctl.init) begin
                    w_c.op = HOP_WRITE;
                    w_c.pos = 8'(r_merge_pos);
                    w_c.wr = w_hole[r_merge_pos[HI-1:0]];
                    w_c.wr.he = r_merge_end;
                end
            end
            bfpa_hole_cell #(.IDX(g)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_c),
                .i_left(w_l), .i_right(w_r), .o_hole(w_hole[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_merge_fix <= 1'b0;
            for (int j = 0; j < MAX_JOBS; j++) r_job[j] <= '0;
        end else begin
            r_state <= n_state;
            r_merge_fix <= (r_state == S_APPLY) && w_free_ok && w_left && w_right;
            if (o_out_valid && !i_out_stall) r_out_v <= 1'b0;
            if (i_cfg_we) begin
                for (int j = 0; j < MAX_JOBS; j++) r_job[j] <= '0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_req <= i_in_data;
                    r_idx <= '0; r_cnt <= '0; r_found <= 1'b0;
                    r_pos <= '0; r_posf <= 1'b0; r_bsz <= '0; r_best <= '0;
                end
                S_SCAN: if (!w_done_scan) begin
                    r_idx <= r_idx + HW'(1);
                    r_cnt <= r_cnt + HW'(1);
                    if (w_csz >= r_req.req_size && (!r_found || w_csz < r_bsz)) begin
                        r_found <= 1'b1; r_best <= r_idx; r_bsz <= w_csz;
                    end
                    if (!r_posf) begin
                        if (w_cur.hs < w_fs) r_pos <= r_idx + HW'(1);
                        else r_posf <= 1'b1;
                    end
                end
                S_APPLY: begin
                    r_out <= w_res;
                    r_merge_pos <= w_pos_m1;
                    r_merge_end <= w_rh.he;
                    if (w_alloc_ok) begin
                        r_job[w_free_i] <= '{valid: 1'b1, id: r_req.job_id,
                            js: w_best.hs, jsz: r_req.req_size};
                    end
                    if (w_free_ok) r_job[w_hit_i] <= '0;
                end
                S_RESP: r_out_v <= 1'b1;
                default: ;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_resp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> o_out_valid) else $error("result not raised");
    a_hole0_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hole[0].valid && w_hole[(1 % MAX_HOLES)].valid && MAX_HOLES > 1)
        |-> (w_hole[0].he < w_hole[(1 % MAX_HOLES)].hs)) else $error("holes out of order");
`endif
endmodule
`default_nettype wire

@@ dv/bfpa_checker.sv @@
// checker for the best-fit partition allocator: watches both channels and the
// register port, predicts each output word and compares it; depends on bfpa_pkg
`default_nettype none
module bfpa_checker
    import bfpa_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  t_in_word   i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  t_out_word  i_out_data,
    output int         o_errors,
    output int         o_pending
);
    localparam int NH = MAX_HOLES_DEF;
    localparam int NJ = MAX_JOBS_DEF;

    logic [15:0] hole_lo [NH];
    logic [15:0] hole_hi [NH];
    bit          hole_used [NH];
    logic [7:0]  job_tag [NJ];
    logic [15:0] job_base [NJ];
    logic [15:0] job_len [NJ];
    bit          job_used [NJ];
    t_out_word   awaited [$];

    function automatic void rebuild(logic [15:0] total);
        for (int i = 0; i < NH; i++) begin
            hole_lo[i] = '0;
            hole_hi[i] = '0;
            hole_used[i] = 0;
        end
        for (int i = 0; i < NJ; i++) begin
            job_tag[i] = '0;
            job_base[i] = '0;
            job_len[i] = '0;
            job_used[i] = 0;
        end
        if (total != 0) begin
            hole_lo[0] = 16'd1;
            hole_hi[0] = total;
            hole_used[0] = 1;
        end
    endfunction

    function automatic int hole_count();
        int n;
        n = 0;
        while (n < NH && hole_used[n]) n++;
        return n;
    endfunction

    function automatic int job_lookup(logic [7:0] id);
        for (int i = 0; i < NJ; i++)
            if (job_used[i] && job_tag[i] == id) return i;
        return -1;
    endfunction

    function automatic void drop_hole(int k, int n);
        for (int i = k; i + 1 < n; i++) begin
            hole_lo[i] = hole_lo[i + 1];
            hole_hi[i] = hole_hi[i + 1];
        end
        hole_lo[n - 1] = '0;
        hole_hi[n - 1] = '0;
        hole_used[n - 1] = 0;
    endfunction

    function automatic t_out_word carve_region(logic [7:0] id, logic [15:0] sz);
        t_out_word   r;
        int          n, slot, best;
        logic [16:0] span, best_span;
        r = '0;
        n = hole_count();
        slot = -1;
        best = -1;
        best_span = '0;
        if (job_lookup(id) >= 0) begin
            r.status = ST_DUP;
            return r;
        end
        for (int i = 0; i < NJ; i++)
            if (!job_used[i] && slot < 0) slot = i;
        if (slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        for (int i = 0; i < n; i++) begin
            span = {1'b0, hole_hi[i]} - {1'b0, hole_lo[i]} + 17'd1;
            if (sz != 0 && span >= {1'b0, sz} && (best < 0 || span < best_span)) begin
                best = i;
                best_span = span;
            end
        end
        if (best < 0) begin
            r.status = ST_NOFIT;
            return r;
        end
        r.status = ST_OK;
        r.region_start = hole_lo[best];
        r.region_size = sz;
        if (best_span == {1'b0, sz}) drop_hole(best, n);
        else hole_lo[best] = hole_lo[best] + sz;
        job_used[slot] = 1;
        job_tag[slot] = id;
        job_base[slot] = r.region_start;
        job_len[slot] = sz;
        return r;
    endfunction

    function automatic t_out_word return_region(logic [7:0] id);
        t_out_word   r;
        int          n, j, pos;
        logic [15:0] s, e;
        bit          lt, rt;
        r = '0;
        n = hole_count();
        j = job_lookup(id);
        if (j < 0) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        s = job_base[j];
        e = s + job_len[j] - 16'd1;
        pos = 0;
        while (pos < n && hole_lo[pos] < s) pos++;
        lt = pos > 0 && ({1'b0, hole_hi[pos - 1]} + 17'd1 == {1'b0, s});
        rt = pos < n && ({1'b0, e} + 17'd1 == {1'b0, hole_lo[pos]});
        if (lt && rt) begin
            hole_hi[pos - 1] = hole_hi[pos];
            drop_hole(pos, n);
        end else if (lt) begin
            hole_hi[pos - 1] = e;
        end else if (rt) begin
            hole_lo[pos] = s;
        end else begin
            if (n >= NH) begin
                r.status = ST_FULL;
                return r;
            end
            for (int i = n; i > pos; i--) begin
                hole_lo[i] = hole_lo[i - 1];
                hole_hi[i] = hole_hi[i - 1];
            end
            hole_lo[pos] = s;
            hole_hi[pos] = e;
            hole_used[n] = 1;
        end
        r.status = ST_OK;
        r.region_start = s;
        r.region_size = job_len[j];
        job_used[j] = 0;
        job_tag[j] = '0;
        job_base[j] = '0;
        job_len[j] = '0;
        return r;
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            rebuild(RESET_TOTAL);
            awaited.delete();
        end else begin
            if (i_cfg_we) rebuild(i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                if (awaited.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("unexpected output word %h", i_out_data);
                end else begin
                    want = awaited.pop_front();
                    if (want.status !== i_out_data.status
                        || want.region_start !== i_out_data.region_start
                        || want.region_size !== i_out_data.region_size) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("mismatch: expected st %0d start %0d size %0d, got st %0d start %0d size %0d",
                                     want.status, want.region_start, want.region_size,
                                     i_out_data.status, i_out_data.region_start,
                                     i_out_data.region_size);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.mode == MODE_ALLOC)
                    awaited.push_back(carve_region(i_in_data.job_id, i_in_data.req_size));
                else
                    awaited.push_back(return_region(i_in_data.job_id));
            end
        end
        o_pending = awaited.size();
    end
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// testbench top for the best-fit partition allocator: clock, reset, stimulus
// and verdict; depends on bfpa_pkg, bfpa_checker and the allocator rtl
`default_nettype none
module tb_top;
    import bfpa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          quiet;
    logic [15:0] total;

    best_fit_partition_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    bfpa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to fill the block
    initial begin
        int rc;
        rc = 0;
        i_out_stall = 0;
        forever begin
            @(negedge i_clk);
            rc++;
            if (rc >= 1500 && rc < 1800) i_out_stall = 1;
            else if (quiet) i_out_stall = 0;
            else i_out_stall = ($urandom_range(99) < 17);
        end
    end

    task automatic send_word(logic m, logic [7:0] id, logic [15:0] sz);
        if (!quiet)
            while ($urandom_range(99) < 17) begin
                @(negedge i_clk);
                i_in_valid = 0;
            end
        @(negedge i_clk);
        i_in_valid = 1;
        i_in_data = '{mode: m, job_id: id, req_size: sz};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_total(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_data = v;
        total = v;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic random_words(int count);
        logic [7:0]  id;
        logic [15:0] sz;
        int          r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            id = (r < 90) ? 8'($urandom_range(0, 19)) : 8'($urandom_range(0, 255));
            r = $urandom_range(99);
            if (r < 80) sz = 16'($urandom_range(1, (total > 8) ? total / 6 : 1));
            else if (r < 95) sz = 16'($urandom);
            else sz = 16'd0;
            send_word($urandom_range(99) < 55 ? MODE_ALLOC : MODE_FREE, id, sz);
        end
    endtask

    initial begin
        quiet = 0;
        total = RESET_TOTAL;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_in_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_word(MODE_ALLOC, 8'd1, 16'd0);
        send_word(MODE_ALLOC, 8'd2, 16'hFFFF);
        send_word(MODE_ALLOC, 8'd1, 16'd100);
        send_word(MODE_ALLOC, 8'd1, 16'd5);
        send_word(MODE_ALLOC, 8'd255, 16'd540);
        send_word(MODE_ALLOC, 8'd3, 16'd1);
        send_word(MODE_FREE, 8'd7, 16'hFFFF);
        send_word(MODE_FREE, 8'd1, 16'd0);
        send_word(MODE_ALLOC, 8'd128, 16'd40);
        send_word(MODE_FREE, 8'd255, 16'd0);
        send_word(MODE_FREE, 8'd128, 16'd0);
        drain();
        write_total(16'd32);
        for (int i = 0; i < 16; i++) send_word(MODE_ALLOC, 8'(10 + i), 16'd1);
        send_word(MODE_ALLOC, 8'd26, 16'd1);
        send_word(MODE_FREE, 8'd11, 16'd0);
        send_word(MODE_FREE, 8'd13, 16'd0);
        send_word(MODE_FREE, 8'd12, 16'd0);
        drain();

        random_words(110);
        drain();
        write_total(16'd0);
        random_words(30);
        drain();
        write_total(16'd1);
        random_words(40);
        drain();
        write_total(16'hFFFF);
        quiet = 1;
        random_words(120);
        quiet = 0;
        drain();
        write_total(16'd200);
        random_words(150);
        drain();
        write_total(RESET_TOTAL);
        random_words(120);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
sv/bfpa_pkg.sv
sv/bfpa_hole_cell.sv
sv/best_fit_partition_allocator.sv
dv/bfpa_checker.sv
dv/tb_top.sv
